// ===== sv/hsvr_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvr_pkg
// types and constants shared by the hsv to rgb pipeline
// ----------------------------------------------------------------------------
package hsvr_pkg;

	localparam int HUE_W   = 16;
	localparam int PCT_W   = 7;
	localparam int LVL_W   = 8;
	localparam int DEG_W   = 9;
	localparam int SEXT_W  = 3;
	localparam int OFF_W   = 6;
	localparam int SPROD_W = 13;
	localparam int RAMP_W  = 21;

	localparam logic [PCT_W-1:0]   PCT_FULL  = 7'd100;
	localparam logic [DEG_W-1:0]   DEG_FULL  = 9'd360;
	localparam logic [OFF_W-1:0]   DEG_SEXT  = 6'd60;
	localparam logic [SPROD_W-1:0] RAMP_DEN  = 13'd6000;

	// reciprocals for exact truncating division over the reachable ranges
	localparam logic [15:0] RECIP_360  = 16'd46604;   // >> 24
	localparam logic [13:0] RECIP_100  = 14'd10486;   // >> 20
	localparam logic [10:0] RECIP_60   = 11'd1093;    // >> 16
	localparam logic [19:0] RECIP_6000 = 20'd715828;  // >> 32

	typedef enum logic [SEXT_W-1:0] {
		SEXT_RED_YEL,
		SEXT_YEL_GRN,
		SEXT_GRN_CYN,
		SEXT_CYN_BLU,
		SEXT_BLU_MAG,
		SEXT_MAG_RED
	} sextant_t;

	typedef struct packed {
		logic               valid;
		logic [DEG_W-1:0]   hue;
		sextant_t           sext;
		logic [PCT_W-1:0]   sat;
		logic [LVL_W-1:0]   lv;
		logic [LVL_W-1:0]   low;
	} mid_t;

endpackage

// ===== sv/hsv_to_rgb_percent.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_percent
// hsv color (hue in degrees, saturation and value in percent) to 8-bit rgb
// ----------------------------------------------------------------------------
// Takes one request per clock while not stalled and returns its rgb result
// in order. The six register stages are: input clamp and reciprocal
// multiplies, hue reduction mod 360, sextant split and low level, ramp
// saturation products, ramp level products, and the divide by 6000 with
// sextant routing into the output register. When the output is held by
// tready low the whole pipeline freezes and s_axis_tready drops, so nothing
// is lost or repeated; with tready high throughput is one item per cycle.
// ----------------------------------------------------------------------------
module hsv_to_rgb_percent (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // hue[15:0], saturation[22:16], brightness[29:23]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

	logic                          en;
	hsvr_pkg::mid_t                mid;
	logic [hsvr_pkg::LVL_W-1:0]    red, green, blue;

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	hsvr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (s_axis_tvalid),
		.hue        (s_axis_tdata[15:0]),
		.saturation (s_axis_tdata[22:16]),
		.brightness (s_axis_tdata[29:23]),
		.mid        (mid)
	);

	hsvr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.mid       (mid),
		.out_valid (m_axis_tvalid),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	assign m_axis_tdata = {blue, green, red};

endmodule

// ===== sv/hsvr_front.sv =====
// ----------------------------------------------------------------------------
// hsvr_front
// clamps inputs, reduces hue to 0..359 and sextant, scales value, forms low
// ----------------------------------------------------------------------------
module hsvr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [hsvr_pkg::HUE_W-1:0]    hue,
	input  logic [hsvr_pkg::PCT_W-1:0]    saturation,
	input  logic [hsvr_pkg::PCT_W-1:0]    brightness,
	output hsvr_pkg::mid_t                mid
);

	logic [hsvr_pkg::PCT_W-1:0] sat_c, val_c;
	logic [14:0]                v255;
	logic [28:0]                lv_prod;
	logic [31:0]                hq_prod;

	logic                       valid_s1;
	logic [hsvr_pkg::HUE_W-1:0] hue_s1;
	logic [7:0]                 q_s1;
	logic [hsvr_pkg::PCT_W-1:0] sat_s1;
	logic [hsvr_pkg::LVL_W-1:0] lv_s1;

	logic [15:0]                qm;
	logic [15:0]                h16;

	logic                       valid_s2;
	logic [hsvr_pkg::DEG_W-1:0] h_s2;
	logic [hsvr_pkg::PCT_W-1:0] sat_s2;
	logic [hsvr_pkg::LVL_W-1:0] lv_s2;
	logic [14:0]                lowp_s2;

	logic [19:0]                sx_prod;
	logic [28:0]                low_prod;

	logic                       valid_s3;
	logic [hsvr_pkg::DEG_W-1:0] h_s3;
	logic [hsvr_pkg::SEXT_W-1:0] sext_s3;
	logic [hsvr_pkg::PCT_W-1:0] sat_s3;
	logic [hsvr_pkg::LVL_W-1:0] lv_s3;
	logic [hsvr_pkg::LVL_W-1:0] low_s3;

	always_comb begin
		sat_c   = (saturation > hsvr_pkg::PCT_FULL) ? hsvr_pkg::PCT_FULL : saturation;
		val_c   = (brightness > hsvr_pkg::PCT_FULL) ? hsvr_pkg::PCT_FULL : brightness;
		v255    = {val_c, 8'b0} - {8'b0, val_c};
		lv_prod = 29'(v255) * 29'(hsvr_pkg::RECIP_100);
		hq_prod = 32'(hue) * 32'(hsvr_pkg::RECIP_360);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_s1 <= hue;
			q_s1   <= hq_prod[31:24];
			sat_s1 <= sat_c;
			lv_s1  <= lv_prod[27:20];
		end
	end

	always_comb begin
		qm  = 16'(q_s1) * 16'(hsvr_pkg::DEG_FULL);
		h16 = hue_s1 - qm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s2    <= h16[hsvr_pkg::DEG_W-1:0];
			sat_s2  <= sat_s1;
			lv_s2   <= lv_s1;
			lowp_s2 <= 15'(lv_s1) * 15'(hsvr_pkg::PCT_FULL - sat_s1);
		end
	end

	always_comb begin
		sx_prod  = 20'(h_s2) * 20'(hsvr_pkg::RECIP_60);
		low_prod = 29'(lowp_s2) * 29'(hsvr_pkg::RECIP_100);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s3    <= h_s2;
			sext_s3 <= sx_prod[18:16];
			sat_s3  <= sat_s2;
			lv_s3   <= lv_s2;
			low_s3  <= low_prod[27:20];
		end
	end

	always_comb begin
		mid.valid = valid_s3;
		mid.hue   = h_s3;
		mid.sext  = hsvr_pkg::sextant_t'(sext_s3);
		mid.sat   = sat_s3;
		mid.lv    = lv_s3;
		mid.low   = low_s3;
	end

endmodule

// ===== sv/hsvr_back.sv =====
// ----------------------------------------------------------------------------
// hsvr_back
// forms the falling and rising ramps and routes levels by sextant
// ----------------------------------------------------------------------------
module hsvr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  hsvr_pkg::mid_t                mid,
	output logic                          out_valid,
	output logic [hsvr_pkg::LVL_W-1:0]    red,
	output logic [hsvr_pkg::LVL_W-1:0]    green,
	output logic [hsvr_pkg::LVL_W-1:0]    blue
);

	logic [hsvr_pkg::DEG_W-1:0]   sm;
	logic [hsvr_pkg::DEG_W-1:0]   offd;
	logic [hsvr_pkg::OFF_W-1:0]   off;
	logic [hsvr_pkg::SPROD_W-1:0] sa, s60;

	logic                         valid_s4;
	hsvr_pkg::sextant_t           sext_s4;
	logic [hsvr_pkg::LVL_W-1:0]   lv_s4;
	logic [hsvr_pkg::LVL_W-1:0]   low_s4;
	logic [hsvr_pkg::SPROD_W-1:0] sa_s4;
	logic [hsvr_pkg::SPROD_W-1:0] sb_s4;

	logic                         valid_s5;
	hsvr_pkg::sextant_t           sext_s5;
	logic [hsvr_pkg::LVL_W-1:0]   lv_s5;
	logic [hsvr_pkg::LVL_W-1:0]   low_s5;
	logic [hsvr_pkg::RAMP_W-1:0]  fallp_s5;
	logic [hsvr_pkg::RAMP_W-1:0]  risep_s5;

	logic [40:0]                  fall_prod, rise_prod;
	logic [hsvr_pkg::LVL_W-1:0]   fall, rise;
	logic [hsvr_pkg::LVL_W-1:0]   r_d, g_d, b_d;

	logic                         valid_s6;

	always_comb begin
		sm   = 9'(mid.sext) * 9'(hsvr_pkg::DEG_SEXT);
		offd = mid.hue - sm;
		off  = offd[hsvr_pkg::OFF_W-1:0];
		sa   = 13'(mid.sat) * 13'(off);
		s60  = 13'(mid.sat) * 13'(hsvr_pkg::DEG_SEXT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= mid.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sext_s4 <= mid.sext;
			lv_s4   <= mid.lv;
			low_s4  <= mid.low;
			sa_s4   <= sa;
			sb_s4   <= s60 - sa;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sext_s5  <= sext_s4;
			lv_s5    <= lv_s4;
			low_s5   <= low_s4;
			fallp_s5 <= 21'(lv_s4) * 21'(hsvr_pkg::RAMP_DEN - sa_s4);
			risep_s5 <= 21'(lv_s4) * 21'(hsvr_pkg::RAMP_DEN - sb_s4);
		end
	end

	always_comb begin
		fall_prod = 41'(fallp_s5) * 41'(hsvr_pkg::RECIP_6000);
		rise_prod = 41'(risep_s5) * 41'(hsvr_pkg::RECIP_6000);
		fall      = fall_prod[39:32];
		rise      = rise_prod[39:32];
		unique case (sext_s5)
			hsvr_pkg::SEXT_RED_YEL: begin
				r_d = lv_s5;  g_d = rise;  b_d = low_s5;
			end
			hsvr_pkg::SEXT_YEL_GRN: begin
				r_d = fall;   g_d = lv_s5; b_d = low_s5;
			end
			hsvr_pkg::SEXT_GRN_CYN: begin
				r_d = low_s5; g_d = lv_s5; b_d = rise;
			end
			hsvr_pkg::SEXT_CYN_BLU: begin
				r_d = low_s5; g_d = fall;  b_d = lv_s5;
			end
			hsvr_pkg::SEXT_BLU_MAG: begin
				r_d = rise;   g_d = low_s5; b_d = lv_s5;
			end
			default: begin
				r_d = lv_s5;  g_d = low_s5; b_d = fall;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red   <= r_d;
			green <= g_d;
			blue  <= b_d;
		end
	end

	assign out_valid = valid_s6;

endmodule
